// ----- src/byte_stuffed_frame_receiver_crc8_top_assert.svh -----
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_crc8_top_assert.svh
// Assertion macros used by the frame receiver checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFED_FRAME_RECEIVER_CRC8_TOP_ASSERT_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_CRC8_TOP_ASSERT_SVH

// same-cycle implication
`define BSFR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame receiver assertion failed");

// next-cycle implication
`define BSFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame receiver assertion failed");

`endif

// ----- src/bsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// bsfr_pkg
// Codes, constants and the CRC-8 update for the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
package bsfr_pkg;

   // stuffing codes
   localparam logic [7:0] FEND_CODE  = 8'hC0;
   localparam logic [7:0] FESC_CODE  = 8'hDB;
   localparam logic [7:0] TFEND_CODE = 8'hDC;
   localparam logic [7:0] TFESC_CODE = 8'hDD;

   // reflected CRC-8, poly 0x31 reversed
   localparam logic [7:0] CRC_SEED = 8'h82;
   localparam logic [7:0] CRC_POLY = 8'h8C;

   // receive phases
   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_CMD  = 3'd1;
   localparam logic [2:0] PH_LEN  = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_DONE = 3'd4;

   // input operations
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // result kinds
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ----- src/byte_stuffed_frame_receiver_crc8_top.sv -----
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_crc8_top
// Byte-stuffed frame receiver with CRC-8 check.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while req_ready is high: a received UART
// byte or a release. Each byte is destuffed, checked and folded into the CRC
// in the cycle it is accepted, and any result is registered in a two-entry
// output buffer whose head drives rsp_. req_ready drops only when both
// buffer entries hold results that have not been taken. After a frame
// complete result the receiver ignores bytes until a release transaction.
// Payload length is clamped to MAX_PAYLOAD; index and length ports are
// wide enough to hold MAX_PAYLOAD.
module byte_stuffed_frame_receiver_crc8_top import bsfr_pkg::*; #(
   parameter int MAX_PAYLOAD = 36,
   localparam int LEN_W      = $clog2(MAX_PAYLOAD + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_op,
   input  logic [7:0]       req_rx_byte,
   input  logic             req_framing_error,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_kind,
   output logic [LEN_W-1:0] rsp_payload_index,
   output logic [7:0]       rsp_payload_byte,
   output logic [7:0]       rsp_command,
   output logic [LEN_W-1:0] rsp_frame_length,
   output logic             rsp_crc_ok
);

   localparam int RES_W = 2 * LEN_W + 18;

   logic             accept;
   logic             full;
   logic             res_valid;
   logic             res_kind;
   logic [LEN_W-1:0] res_index;
   logic [7:0]       res_byte;
   logic [7:0]       res_command;
   logic [LEN_W-1:0] res_length;
   logic             res_crc_ok;
   logic [RES_W-1:0] res_data;
   logic [RES_W-1:0] out_data;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   bsfr_rx_core #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .LEN_W      (LEN_W)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .op           (req_op),
      .rx_byte      (req_rx_byte),
      .framing_error(req_framing_error),
      .res_valid    (res_valid),
      .res_kind     (res_kind),
      .res_index    (res_index),
      .res_byte     (res_byte),
      .res_command  (res_command),
      .res_length   (res_length),
      .res_crc_ok   (res_crc_ok)
   );

   assign res_data = {res_kind, res_index, res_byte, res_command, res_length, res_crc_ok};

   bsfr_out_queue #(
      .WIDTH(RES_W)
   ) u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (res_valid),
      .push_data(res_data),
      .out_ready(rsp_ready),
      .out_valid(rsp_valid),
      .out_data (out_data),
      .full     (full)
   );

   assign {rsp_kind, rsp_payload_index, rsp_payload_byte, rsp_command,
           rsp_frame_length, rsp_crc_ok} = out_data;

endmodule

// ----- src/bsfr_rx_core.sv -----
// ----------------------------------------------------------------------------
// bsfr_rx_core
// Receive state, destuffing, length clamp and CRC; one transaction per cycle.
// ----------------------------------------------------------------------------
module bsfr_rx_core import bsfr_pkg::*; #(
   parameter int MAX_PAYLOAD = 36,
   parameter int LEN_W       = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             op,
   input  logic [7:0]       rx_byte,
   input  logic             framing_error,
   output logic             res_valid,
   output logic             res_kind,
   output logic [LEN_W-1:0] res_index,
   output logic [7:0]       res_byte,
   output logic [7:0]       res_command,
   output logic [LEN_W-1:0] res_length,
   output logic             res_crc_ok
);

   localparam logic [7:0] MAX_BYTE = 8'(MAX_PAYLOAD);

   logic [2:0]       phase_ff, phase_in;
   logic             esc_ff, esc_in;
   logic [LEN_W-1:0] pos_ff, pos_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       crc_ff, crc_in;

   logic [7:0] data;
   logic       bad_escape;
   logic [7:0] len_clamp;
   logic [7:0] crc_byte;
   logic [7:0] crc_upd;

   // escape mapping
   always_comb begin
      data       = rx_byte;
      bad_escape = 1'b0;
      if (esc_ff) begin
         if (rx_byte == TFESC_CODE) begin
            data = FESC_CODE;
         end else if (rx_byte == TFEND_CODE) begin
            data = FEND_CODE;
         end else begin
            bad_escape = 1'b1;
         end
      end
   end

   assign len_clamp = (data > MAX_BYTE) ? MAX_BYTE : data;
   assign crc_byte  = (phase_ff == PH_LEN) ? len_clamp : data;
   assign crc_upd   = crc8_update(crc_ff, crc_byte);

   always_comb begin
      phase_in    = phase_ff;
      esc_in      = esc_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      cmd_in      = cmd_ff;
      crc_in      = crc_ff;
      res_valid   = 1'b0;
      res_kind    = KIND_DATA;
      res_index   = '0;
      res_byte    = '0;
      res_command = '0;
      res_length  = '0;
      res_crc_ok  = 1'b0;
      if (accept) begin
         if (op == OP_RELEASE) begin
            if (phase_ff == PH_DONE) begin
               phase_in = PH_IDLE;
            end
         end else if (phase_ff == PH_DONE) begin
            // finished frame held until release
         end else if (framing_error) begin
            phase_in = PH_IDLE;
         end else if (rx_byte == FEND_CODE) begin
            phase_in = PH_CMD;
            pos_in   = '0;
            esc_in   = 1'b0;
            crc_in   = CRC_SEED;
         end else if (rx_byte == FESC_CODE) begin
            esc_in = 1'b1;
         end else if (bad_escape) begin
            // escape flag stays set until next FEND or a TFEND or TFESC byte
            phase_in = PH_IDLE;
         end else begin
            esc_in = 1'b0;
            unique case (phase_ff)
               PH_CMD: begin
                  cmd_in   = data;
                  crc_in   = crc_upd;
                  phase_in = PH_LEN;
               end
               PH_LEN: begin
                  len_in   = LEN_W'(len_clamp);
                  crc_in   = crc_upd;
                  pos_in   = '0;
                  phase_in = PH_DATA;
               end
               PH_DATA: begin
                  crc_in    = crc_upd;
                  res_valid = 1'b1;
                  if (pos_ff == len_ff) begin
                     phase_in    = PH_DONE;
                     res_kind    = KIND_FRAME;
                     res_command = cmd_ff;
                     res_length  = len_ff;
                     res_crc_ok  = (crc_upd == 8'h00);
                  end else begin
                     res_kind  = KIND_DATA;
                     res_index = pos_ff;
                     res_byte  = data;
                     pos_in    = pos_ff + 1'b1;
                  end
               end
               PH_IDLE: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         esc_ff   <= 1'b0;
         pos_ff   <= '0;
         len_ff   <= '0;
         cmd_ff   <= '0;
         crc_ff   <= CRC_SEED;
      end else begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         cmd_ff   <= cmd_in;
         crc_ff   <= crc_in;
      end
   end

endmodule

// ----- src/bsfr_out_queue.sv -----
// ----------------------------------------------------------------------------
// bsfr_out_queue
// Two-entry result buffer; head drives the result channel.
// ----------------------------------------------------------------------------
module bsfr_out_queue #(
   parameter int WIDTH = 30
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             out_ready,
   output logic             out_valid,
   output logic [WIDTH-1:0] out_data,
   output logic             full
);

   logic [1:0]       count_ff, count_in;
   logic [WIDTH-1:0] head_ff, head_in;
   logic [WIDTH-1:0] tail_ff, tail_in;
   logic             pop;

   assign out_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign out_data  = head_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = 2'(count_ff + {1'b0, push} - {1'b0, pop});
      if (pop) begin
         if (count_ff == 2'd2) begin
            head_in = tail_ff;
         end else if (push) begin
            head_in = push_data;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_in = push_data;
         end else begin
            tail_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ----- src/bsfr_checker.sv -----
// ----------------------------------------------------------------------------
// bsfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_stuffed_frame_receiver_crc8_top_assert.svh"

module bsfr_checker import bsfr_pkg::*; #(
   parameter int MAX_PAYLOAD = 36,
   localparam int LEN_W      = $clog2(MAX_PAYLOAD + 1)
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_op,
   input logic [7:0]       req_rx_byte,
   input logic             req_framing_error,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_kind,
   input logic [LEN_W-1:0] rsp_payload_index,
   input logic [7:0]       rsp_payload_byte,
   input logic [7:0]       rsp_command,
   input logic [LEN_W-1:0] rsp_frame_length,
   input logic             rsp_crc_ok
);

   logic req_seen;

   // request side is only observed
   assign req_seen = req_valid ^ req_op ^ req_framing_error ^ (^req_rx_byte);

   // a stalled result must hold
   `BSFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_payload_index) && $stable(rsp_payload_byte) && $stable(rsp_command) && $stable(rsp_frame_length) && $stable(rsp_crc_ok))

   // backpressure only with a result backlog
   `BSFR_ASSERT_IMPLY(a_stall_backlog, clock, reset, !req_ready, rsp_valid)

   // buffer empty and input open right after reset
   `BSFR_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready)

   // payload index stays below clamp, frame length within it
   `BSFR_ASSERT_IMPLY(a_index_range, clock, reset, rsp_valid && (rsp_kind == KIND_DATA) && (req_seen || !req_seen), rsp_payload_index < MAX_PAYLOAD)
   `BSFR_ASSERT_IMPLY(a_length_range, clock, reset, rsp_valid && (rsp_kind == KIND_FRAME), rsp_frame_length <= MAX_PAYLOAD)

endmodule

bind byte_stuffed_frame_receiver_crc8_top bsfr_checker #(
   .MAX_PAYLOAD(MAX_PAYLOAD)
) u_bsfr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_op           (req_op),
   .req_rx_byte      (req_rx_byte),
   .req_framing_error(req_framing_error),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_payload_index(rsp_payload_index),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_command      (rsp_command),
   .rsp_frame_length (rsp_frame_length),
   .rsp_crc_ok       (rsp_crc_ok)
);

// ----- test/byte_stuffed_frame_receiver_crc8_top_test.sv -----
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_crc8_top_test
// Drives stuffed UART byte streams and release transactions into the frame
// receiver while the sender pauses in bursts and the result side stalls on
// its own pattern. A behavioral receiver tracks phase, escape state and the
// running CRC-8, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver_crc8_top_test;
   import bsfr_pkg::*;

   localparam int MAX_LEN     = 36;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int DRAIN       = 20;
   localparam int ITEM_TARGET = 1300;

   typedef struct packed {
      logic       kind;
      logic [5:0] index;
      logic [7:0] value;
      logic [7:0] cmd;
      logic [5:0] len;
      logic       ok;
   } rx_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_op = OP_BYTE;
   logic [7:0] req_rx_byte = 8'h00;
   logic       req_framing_error = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_kind;
   logic [5:0] rsp_payload_index;
   logic [7:0] rsp_payload_byte;
   logic [7:0] rsp_command;
   logic [5:0] rsp_frame_length;
   logic       rsp_crc_ok;

   // receiver state as tracked by the testbench
   logic [2:0] rx_phase = PH_IDLE;
   logic       esc_armed = 1'b0;
   logic [5:0] next_index = '0;
   logic [5:0] body_len = '0;
   logic [7:0] frame_cmd = '0;
   logic [7:0] crc_run = CRC_SEED;

   rx_result_type pending_results[$];
   logic [7:0]    body_bytes[$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            item_count = 0;

   // sender and receiver pacing
   logic tx_bursty = 1'b0;
   logic req_held = 1'b0;
   int   burst_left = 4;
   int   rsp_mode = 0;
   logic rsp_run_ready = 1'b1;
   int   rsp_run_left = 0;

   byte_stuffed_frame_receiver_crc8_top #(.MAX_PAYLOAD(MAX_LEN)) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_rx_byte       (req_rx_byte),
      .req_framing_error (req_framing_error),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_payload_index (rsp_payload_index),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_command       (rsp_command),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_crc_ok        (rsp_crc_ok)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("byte_stuffed_frame_receiver_crc8_top: mismatch");
         $finish;
      end
   end

   // serial form of the reflected CRC-8, one data bit per step
   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] d);
      logic [7:0] r;
      logic       fb;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         fb = r[0] ^ d[k];
         r  = r >> 1;
         if (fb) r = r ^ CRC_POLY;
      end
      return r;
   endfunction

   // biased toward the stuffing codes and the byte extremes
   function automatic logic [7:0] pick_byte();
      logic [7:0] hot[6];
      hot = '{FEND_CODE, FESC_CODE, TFEND_CODE, TFESC_CODE, 8'h00, 8'hFF};
      if ($urandom_range(0, 3) == 0) return hot[$urandom_range(0, 5)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] bad_escape_byte();
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255));
      while (v inside {FEND_CODE, FESC_CODE, TFEND_CODE, TFESC_CODE});
      return v;
   endfunction

   // updates the tracked state for one accepted transaction
   task automatic predict_receiver(input logic op, input logic [7:0] b, input logic fe);
      rx_result_type res;
      logic [7:0]    v;
      v = b;
      res = '0;
      if (op == OP_RELEASE) begin
         if (rx_phase == PH_DONE) rx_phase = PH_IDLE;
      end else if (rx_phase == PH_DONE) begin
         // finished frame holds until release
      end else if (fe) begin
         rx_phase = PH_IDLE;           // escape state survives a framing error
      end else if (v == FEND_CODE) begin
         rx_phase   = PH_CMD;
         next_index = '0;
         esc_armed  = 1'b0;
         crc_run    = CRC_SEED;
      end else if (v == FESC_CODE) begin
         esc_armed = 1'b1;
      end else if (esc_armed && v != TFESC_CODE && v != TFEND_CODE) begin
         rx_phase = PH_IDLE;           // bad escape leaves esc_armed set
      end else begin
         if (esc_armed) begin
            v = (v == TFESC_CODE) ? FESC_CODE : FEND_CODE;
            esc_armed = 1'b0;
         end
         case (rx_phase)
            PH_CMD: begin
               frame_cmd = v;
               crc_run   = crc8_step(crc_run, v);
               rx_phase  = PH_LEN;
            end
            PH_LEN: begin
               if (v > MAX_LEN) v = 8'(MAX_LEN);
               body_len   = v[5:0];
               crc_run    = crc8_step(crc_run, v);
               next_index = '0;
               rx_phase   = PH_DATA;
            end
            PH_DATA: begin
               crc_run = crc8_step(crc_run, v);
               if (next_index == body_len) begin
                  rx_phase = PH_DONE;
                  res.kind = KIND_FRAME;
                  res.cmd  = frame_cmd;
                  res.len  = body_len;
                  res.ok   = (crc_run == 8'h00);
               end else begin
                  res.kind  = KIND_DATA;
                  res.index = next_index;
                  res.value = v;
                  next_index++;
               end
               pending_results.push_back(res);
            end
            default: ;
         endcase
      end
   endtask

   task automatic send_item(input logic op, input logic [7:0] b, input logic fe);
      req_valid         <= 1'b1;
      req_op            <= op;
      req_rx_byte       <= b;
      req_framing_error <= fe;
      req_held = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_receiver(op, b, fe);
      item_count++;
      if (tx_bursty) begin
         burst_left--;
         if (burst_left <= 0) begin
            req_valid <= 1'b0;
            req_held = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 14);
         end
      end
   endtask

   task automatic send_coded(input logic [7:0] b);
      if (b == FEND_CODE) begin
         send_item(OP_BYTE, FESC_CODE, 1'b0);
         send_item(OP_BYTE, TFEND_CODE, 1'b0);
      end else if (b == FESC_CODE) begin
         send_item(OP_BYTE, FESC_CODE, 1'b0);
         send_item(OP_BYTE, TFESC_CODE, 1'b0);
      end else begin
         send_item(OP_BYTE, b, 1'b0);
      end
   endtask

   task automatic send_release();
      send_item(OP_RELEASE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // full frame; payload from body_bytes first, random after that
   task automatic send_frame(input logic [7:0] cmd_b, input logic [7:0] len_b,
                             input logic crc_good);
      logic [7:0] acc;
      logic [7:0] b;
      int         clen;
      clen = (len_b > MAX_LEN) ? MAX_LEN : len_b;
      acc  = CRC_SEED;
      send_item(OP_BYTE, FEND_CODE, 1'b0);
      send_coded(cmd_b);
      acc = crc8_step(acc, cmd_b);
      send_coded(len_b);
      acc = crc8_step(acc, 8'(clen));
      for (int i = 0; i < clen; i++) begin
         b = (body_bytes.size() > 0) ? body_bytes.pop_front() : pick_byte();
         send_coded(b);
         acc = crc8_step(acc, b);
      end
      body_bytes.delete();
      // the CRC byte equal to the running value zeroes the check
      if (!crc_good) acc = acc ^ (8'h01 << $urandom_range(0, 7));
      send_coded(acc);
   endtask

   always @(posedge clock) begin
      case (rsp_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (rsp_run_left == 0) begin
               rsp_run_ready = !rsp_run_ready;
               rsp_run_left  = rsp_run_ready ? $urandom_range(1, 8) : $urandom_range(1, 16);
            end
            rsp_run_left--;
            rsp_ready <= rsp_run_ready;
         end
      endcase
   end

   always @(posedge clock) begin : check_results
      rx_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0h", rsp_kind);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0h, got %0h", want.kind, rsp_kind);
               mismatch_count++;
            end
            if (rsp_payload_index !== want.index) begin
               $error("payload_index: expected %0d, got %0d", want.index, rsp_payload_index);
               mismatch_count++;
            end
            if (rsp_payload_byte !== want.value) begin
               $error("payload_byte: expected %0h, got %0h", want.value, rsp_payload_byte);
               mismatch_count++;
            end
            if (rsp_command !== want.cmd) begin
               $error("command: expected %0h, got %0h", want.cmd, rsp_command);
               mismatch_count++;
            end
            if (rsp_frame_length !== want.len) begin
               $error("frame_length: expected %0d, got %0d", want.len, rsp_frame_length);
               mismatch_count++;
            end
            if (rsp_crc_ok !== want.ok) begin
               $error("crc_ok: expected %0h, got %0h", want.ok, rsp_crc_ok);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_basic_frames();
      tx_bursty = 1'b0;
      rsp_mode  = 0;
      send_frame(8'h00, 8'd0, 1'b1);
      send_release();
      // stuffed command and stuffed payload bytes
      body_bytes = '{FEND_CODE, FESC_CODE};
      send_frame(FEND_CODE, 8'd2, 1'b1);
      send_release();
      body_bytes = '{8'hFF};
      send_frame(8'hFF, 8'd1, 1'b0);
      send_release();
   endtask

   task automatic test_special_cases();
      tx_bursty = 1'b1;
      rsp_mode  = 1;
      send_release();                                  // ignored, nothing done
      send_item(OP_BYTE, FESC_CODE, 1'b0);              // escape while idle
      send_item(OP_BYTE, TFEND_CODE, 1'b0);             // destuffed, dropped
      send_item(OP_BYTE, 8'h33, 1'b0);
      // framing error mid frame, trailing bytes dropped
      send_item(OP_BYTE, FEND_CODE, 1'b0);
      send_item(OP_BYTE, 8'h12, 1'b0);
      send_item(OP_BYTE, 8'h05, 1'b1);
      send_item(OP_BYTE, 8'h05, 1'b0);
      // bad escape
      send_item(OP_BYTE, FEND_CODE, 1'b0);
      send_item(OP_BYTE, FESC_CODE, 1'b0);
      send_item(OP_BYTE, 8'h41, 1'b0);
      send_item(OP_BYTE, TFESC_CODE, 1'b0);
      // escape byte carrying a framing error aborts the frame, then a new frame
      send_item(OP_BYTE, FEND_CODE, 1'b0);
      send_item(OP_BYTE, 8'h21, 1'b0);
      send_item(OP_BYTE, 8'd3, 1'b0);
      send_item(OP_BYTE, 8'hA5, 1'b0);
      send_item(OP_BYTE, FESC_CODE, 1'b1);
      send_frame(8'h7E, 8'd1, 1'b1);
      // done: FEND, framing errors and data all ignored until release
      send_item(OP_BYTE, FEND_CODE, 1'b0);
      send_item(OP_BYTE, 8'h80, 1'b1);
      send_item(OP_BYTE, 8'h01, 1'b0);
      send_release();
   endtask

   task automatic test_length_clamp();
      tx_bursty = 1'b1;
      rsp_mode  = 2;
      send_frame(8'h5C, 8'd36, 1'b1);
      send_release();
      send_frame(8'hA3, 8'd37, 1'b1);
      send_release();
      send_frame(8'h01, 8'hFF, 1'b0);
      send_release();
      send_frame(8'hDD, FESC_CODE, 1'b1);
      send_release();
   endtask

   task automatic test_random_traffic();
      int sel;
      int len_pick;
      while (item_count < ITEM_TARGET) begin
         if ($urandom_range(0, 14) == 0) begin
            tx_bursty = ($urandom_range(0, 2) != 0);
            rsp_mode  = $urandom_range(0, 2);
         end
         sel = $urandom_range(0, 99);
         if (sel < 65) begin
            len_pick = $urandom_range(0, 99);
            if (len_pick < 4)
               send_frame(pick_byte(), 8'($urandom_range(37, 255)), $urandom_range(0, 4) != 0);
            else if (len_pick < 12)
               send_frame(pick_byte(), 8'($urandom_range(9, 36)), $urandom_range(0, 4) != 0);
            else
               send_frame(pick_byte(), 8'($urandom_range(0, 8)), $urandom_range(0, 4) != 0);
            repeat ($urandom_range(0, 2))
               send_item(OP_BYTE, pick_byte(), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) != 0) send_release();
         end else if (sel < 78) begin
            // truncated or corrupted frame
            send_item(OP_BYTE, FEND_CODE, 1'b0);
            repeat ($urandom_range(0, 4)) send_coded(pick_byte());
            case ($urandom_range(0, 3))
               0: send_item(OP_BYTE, pick_byte(), 1'b1);
               1: begin
                  send_item(OP_BYTE, FESC_CODE, 1'b0);
                  send_item(OP_BYTE, bad_escape_byte(), 1'b0);
               end
               2: ;
               default: send_item(OP_BYTE, FESC_CODE, 1'($urandom_range(0, 1)));
            endcase
            repeat ($urandom_range(0, 3))
               send_item(OP_BYTE, pick_byte(), $urandom_range(0, 9) == 0);
         end else if (sel < 92) begin
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 9) == 0) send_release();
               else send_item(OP_BYTE, pick_byte(), $urandom_range(0, 19) == 0);
            end
         end else begin
            send_release();
         end
      end
   endtask

   task automatic drain_results();
      if (req_held) req_valid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_frames();
      test_special_cases();
      test_length_clamp();
      test_random_traffic();
      drain_results();
      if (mismatch_count == 0)
         $display("byte_stuffed_frame_receiver_crc8_top: match");
      else
         $display("byte_stuffed_frame_receiver_crc8_top: mismatch");
      $finish;
   end

endmodule
